// ===== rtl/scd_pkg.sv =====
package scd_pkg;

  localparam int WAYS        = 8;
  localparam int INDEX_BITS  = 6;
  localparam int OFFSET_BITS = 6;
  localparam int ADDR_BITS   = 32;

  localparam int SETS      = 1 << INDEX_BITS;
  localparam int TAG_SHIFT = OFFSET_BITS + INDEX_BITS;
  localparam int TAG_BITS  = (ADDR_BITS > TAG_SHIFT) ? (ADDR_BITS - TAG_SHIFT) : 0;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int RANK_W    = $clog2(WAYS);

  localparam int IN_ADDR_W = 32;
  localparam int OUT_WAY_W = 3;
  localparam int OUT_TAG_W = 20;

  typedef logic [1:0] status_t;
  localparam status_t ST_INVALID = 2'd0;
  localparam status_t ST_CLEAN   = 2'd1;
  localparam status_t ST_DIRTY   = 2'd2;

  typedef logic [TAG_W-1:0]      tag_t;
  typedef logic [INDEX_BITS-1:0] set_t;
  typedef logic [WAY_W-1:0]      way_t;
  typedef logic [RANK_W-1:0]     rank_t;

  typedef struct packed {
    tag_t    [WAYS-1:0] tags;
    status_t [WAYS-1:0] stat;
    rank_t   [WAYS-1:0] rank;
  } dir_row_t;

  typedef struct packed {
    logic hit;
    way_t way;
    logic fill;
    logic wb;
    tag_t vtag;
  } lookup_res_t;

  function automatic tag_t get_tag(logic [IN_ADDR_W-1:0] addr);
    logic [63:0] shifted;
    shifted = 64'(addr) >> TAG_SHIFT;
    if (TAG_BITS > 0) begin
      return shifted[TAG_W-1:0];
    end
    return '0;
  endfunction

  function automatic set_t get_set(logic [IN_ADDR_W-1:0] addr);
    return addr[OFFSET_BITS +: INDEX_BITS];
  endfunction

  function automatic dir_row_t reset_row();
    dir_row_t row;
    row.tags = '0;
    row.stat = '0;
    for (int w = 0; w < WAYS; w++) begin
      row.rank[w] = RANK_W'(w);
    end
    return row;
  endfunction

endpackage

// ===== rtl/scd_if.sv =====
interface scd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface scd_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  way;
  logic        fill_needed;
  logic        writeback_needed;
  logic [19:0] victim_tag;

  modport source (output valid, output hit, output way, output fill_needed,
                  output writeback_needed, output victim_tag, input ready);
  modport sink (input valid, input hit, input way, input fill_needed,
                input writeback_needed, input victim_tag, output ready);
endinterface

// ===== rtl/scd_store.sv =====
module scd_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  scd_pkg::set_t     rd_set,
  output scd_pkg::dir_row_t rd_row,
  input  logic              wr_en,
  input  scd_pkg::set_t     wr_set,
  input  scd_pkg::dir_row_t wr_row
);
  import scd_pkg::*;

  dir_row_t         mem [SETS];
  logic [SETS-1:0]  row_valid_r;
  dir_row_t         rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= row_valid_r[rd_set];
      end
    end
  end

  assign rd_row = rd_valid_r ? rd_data_r : reset_row();

endmodule

// ===== rtl/scd_policy.sv =====
module scd_policy (
  input  scd_pkg::dir_row_t    row,
  input  scd_pkg::tag_t        tag,
  input  logic                 wr,
  output scd_pkg::lookup_res_t res,
  output scd_pkg::dir_row_t    new_row
);
  import scd_pkg::*;

  logic [WAYS-1:0] valid;
  logic            hit;
  logic            have_inv;
  way_t            hit_way;
  way_t            inv_way;
  way_t            lru_way;
  way_t            use_way;
  rank_t           old_rank;
  logic            wb;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid[w] = (row.stat[w] != ST_INVALID);
    end

    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && (row.tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end

    have_inv = 1'b0;
    inv_way  = '0;
    lru_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!valid[w]) begin
        have_inv = 1'b1;
        inv_way  = WAY_W'(w);
      end
      if (row.rank[w] == RANK_W'(WAYS - 1)) begin
        lru_way = WAY_W'(w);
      end
    end

    use_way = hit ? hit_way : (have_inv ? inv_way : lru_way);
    wb      = !hit && row.stat[use_way][1];

    res.hit  = hit;
    res.way  = use_way;
    res.fill = !hit;
    res.wb   = wb;
    res.vtag = wb ? row.tags[use_way] : '0;

    new_row = row;
    if (hit) begin
      if (wr) begin
        new_row.stat[use_way] = ST_DIRTY;
      end
    end else begin
      new_row.tags[use_way] = tag;
      new_row.stat[use_way] = wr ? ST_DIRTY : ST_CLEAN;
    end

    old_rank = row.rank[use_way];
    for (int w = 0; w < WAYS; w++) begin
      if (row.rank[w] < old_rank) begin
        new_row.rank[w] = row.rank[w] + 1'b1;
      end
    end
    new_row.rank[use_way] = '0;
  end

endmodule

// ===== rtl/set_assoc_writeback_cache_directory.sv =====
// Each access is a read-modify-write of its set's directory row (set read, then update):
// the row is registered on the input beat, then written back as the result beat is
// registered. A new access waits for that write-back, held while a result is untaken.
// Reset: synchronous, active low; every set reads as all ways invalid with
// recency equal to way number until its row is first written. No clearing pass.
module set_assoc_writeback_cache_directory (
  input logic      clk,
  input logic      rst_n,
  scd_in_if.sink   in_bus,
  scd_out_if.source out_bus
);
  import scd_pkg::*;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t      state_r;
  logic        act_r;
  tag_t        tag_r;
  set_t        set_r;
  logic        out_valid_r;
  logic        out_hit_r;
  logic [2:0]  out_way_r;
  logic        out_fill_r;
  logic        out_wb_r;
  logic [19:0] out_vtag_r;

  logic        accept;
  logic        finish;
  dir_row_t    rd_row;
  dir_row_t    new_row;
  lookup_res_t res;

  logic [WAY_W+OUT_WAY_W-1:0] way_ext;
  logic [TAG_W+OUT_TAG_W-1:0] vtag_ext;

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign finish       = (state_r == S_LOOK) && (!out_valid_r || out_bus.ready);

  scd_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_set (get_set(in_bus.address)),
    .rd_row (rd_row),
    .wr_en  (finish),
    .wr_set (set_r),
    .wr_row (new_row)
  );

  scd_policy u_policy (
    .row     (rd_row),
    .tag     (tag_r),
    .wr      (act_r),
    .res     (res),
    .new_row (new_row)
  );

  assign way_ext  = {{OUT_WAY_W{1'b0}}, res.way};
  assign vtag_ext = {{OUT_TAG_W{1'b0}}, res.vtag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (finish) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      act_r <= in_bus.action;
      tag_r <= get_tag(in_bus.address);
      set_r <= get_set(in_bus.address);
    end
    if (finish) begin
      out_hit_r  <= res.hit;
      out_way_r  <= way_ext[OUT_WAY_W-1:0];
      out_fill_r <= res.fill;
      out_wb_r   <= res.wb;
      out_vtag_r <= vtag_ext[OUT_TAG_W-1:0];
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.hit              = out_hit_r;
  assign out_bus.way              = out_way_r;
  assign out_bus.fill_needed      = out_fill_r;
  assign out_bus.writeback_needed = out_wb_r;
  assign out_bus.victim_tag       = out_vtag_r;

endmodule

// ===== test/tb_set_assoc_writeback_cache_directory.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_writeback_cache_directory;
  import scd_pkg::*;

  typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_t;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic hit;
    way_t way;
    logic fill;
    logic wb;
    tag_t vtag;
  } access_result_t;

  typedef struct {
    access_t        act;
    logic [31:0]    addr;
    bit             given;
    access_result_t res;
  } stim_row_t;

  typedef struct packed {
    bit             given;
    access_result_t res;
  } known_answer_t;

  localparam int PHASE_ITEMS    = 234;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 4;
  localparam int HOT_SETS       = 4;
  localparam int POOL_SIZE      = 10;

  logic clk;
  logic rst_n;

  scd_in_if  in_bus ();
  scd_out_if out_bus ();

  set_assoc_writeback_cache_directory u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  status_t dir_status [SETS][WAYS];
  tag_t    dir_tag    [SETS][WAYS];
  rank_t   dir_rank   [SETS][WAYS];

  access_result_t pending_results[$];
  known_answer_t  known_answers[$];
  stim_row_t      rows[$];
  tag_t           tag_pool[POOL_SIZE];

  int sender_idle_pct;
  int receiver_idle_pct;
  int error_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic access_result_t lookup_and_update(access_t act, logic [31:0] addr);
    set_t           s;
    tag_t           t;
    access_result_t r;
    way_t           use_way;
    way_t           inv_way;
    way_t           lru_way;
    bit             found;
    bit             have_inv;
    rank_t          old_rank;
    s        = addr[OFFSET_BITS +: INDEX_BITS];
    t        = tag_t'(addr >> TAG_SHIFT);
    r        = '0;
    found    = 1'b0;
    have_inv = 1'b0;
    use_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (dir_status[s][w] != ST_INVALID) begin
        if (!found && dir_tag[s][w] == t) begin
          found   = 1'b1;
          use_way = way_t'(w);
        end
      end else begin
        have_inv = 1'b1;
        inv_way  = way_t'(w);
      end
      if (dir_rank[s][w] == rank_t'(WAYS - 1)) lru_way = way_t'(w);
    end
    if (found) begin
      if (act == ACC_WRITE) dir_status[s][use_way] = ST_DIRTY;
    end else begin
      use_way = have_inv ? inv_way : lru_way;
      if (dir_status[s][use_way] >= ST_DIRTY) begin
        r.wb   = 1'b1;
        r.vtag = dir_tag[s][use_way];
      end
      dir_tag[s][use_way]    = t;
      dir_status[s][use_way] = (act == ACC_WRITE) ? ST_DIRTY : ST_CLEAN;
    end
    old_rank = dir_rank[s][use_way];
    for (int w = 0; w < WAYS; w++) begin
      if (dir_rank[s][w] < old_rank) dir_rank[s][w] = dir_rank[s][w] + 1'b1;
    end
    dir_rank[s][use_way] = '0;
    r.hit  = found;
    r.way  = use_way;
    r.fill = !found;
    return r;
  endfunction

  function automatic stim_row_t row(access_t act, logic [31:0] addr, bit given = 1'b0,
                                    access_result_t res = '0);
    stim_row_t r;
    r.act   = act;
    r.addr  = addr;
    r.given = given;
    r.res   = res;
    return r;
  endfunction

  function automatic logic [31:0] rand_addr();
    if ($urandom_range(99) < 75) begin
      return {tag_pool[$urandom_range(POOL_SIZE - 1)], set_t'($urandom_range(HOT_SETS - 1)),
              offset_t'($urandom)};
    end
    return $urandom;
  endfunction

  task automatic send_access(access_t act, logic [31:0] addr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.address <= addr;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    access_result_t exp_r;
    access_result_t got_r;
    known_answer_t  ka;
    bit             moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        exp_r = lookup_and_update(access_t'(in_bus.action), in_bus.address);
        if (known_answers.size() != 0) begin
          ka = known_answers.pop_front();
          if (ka.given) exp_r = ka.res;
        end
        pending_results.push_back(exp_r);
      end
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        got_r = {out_bus.hit, out_bus.way, out_bus.fill_needed, out_bus.writeback_needed,
                 out_bus.victim_tag};
        if (pending_results.size() == 0) begin
          $error("result beat with no access outstanding");
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r.hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, got_r.hit);
            error_count++;
          end
          if (got_r.way !== exp_r.way) begin
            $error("way: expected %0d, got %0d", exp_r.way, got_r.way);
            error_count++;
          end
          if (got_r.fill !== exp_r.fill) begin
            $error("fill_needed: expected %0d, got %0d", exp_r.fill, got_r.fill);
            error_count++;
          end
          if (got_r.wb !== exp_r.wb) begin
            $error("writeback_needed: expected %0d, got %0d", exp_r.wb, got_r.wb);
            error_count++;
          end
          if (got_r.vtag !== exp_r.vtag) begin
            $error("victim_tag: expected 0x%05h, got 0x%05h", exp_r.vtag, got_r.vtag);
            error_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.action     = ACC_READ;
    in_bus.address    = '0;
    rst_n             = 1'b0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    error_count       = 0;
    quiet_cycles      = 0;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        dir_status[s][w] = ST_INVALID;
        dir_tag[s][w]    = '0;
        dir_rank[s][w]   = rank_t'(w);
      end
    end
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = tag_t'($urandom);

    rows.push_back(row(ACC_READ,  32'h0000_0000, 1'b1, {1'b0, 3'd7, 1'b1, 1'b0, 20'h0}));
    rows.push_back(row(ACC_READ,  32'h0000_003F, 1'b1, {1'b1, 3'd7, 1'b0, 1'b0, 20'h0}));
    rows.push_back(row(ACC_WRITE, 32'h0000_0010, 1'b1, {1'b1, 3'd7, 1'b0, 1'b0, 20'h0}));
    rows.push_back(row(ACC_WRITE, 32'hFFFF_FFFF, 1'b1, {1'b0, 3'd7, 1'b1, 1'b0, 20'h0}));
    rows.push_back(row(ACC_READ,  32'hFFFF_FFC0, 1'b1, {1'b1, 3'd7, 1'b0, 1'b0, 20'h0}));
    rows.push_back(row(ACC_WRITE, 32'hFFFF_F000));
    rows.push_back(row(ACC_WRITE, 32'h0000_1000));
    rows.push_back(row(ACC_WRITE, 32'h0000_2000));
    rows.push_back(row(ACC_WRITE, 32'h0000_3000));
    rows.push_back(row(ACC_WRITE, 32'h0000_4000));
    rows.push_back(row(ACC_WRITE, 32'h0000_5000));
    rows.push_back(row(ACC_READ,  32'h0000_6000));
    rows.push_back(row(ACC_READ,  32'h0000_1000));
    rows.push_back(row(ACC_WRITE, 32'h0000_7000));
    rows.push_back(row(ACC_READ,  32'h0000_8000));
    rows.push_back(row(ACC_READ,  32'h0000_9000));
    rows.push_back(row(ACC_READ,  32'h0000_A000));
    rows.push_back(row(ACC_READ,  32'h0000_B000));
    rows.push_back(row(ACC_READ,  32'h0000_C000));
    rows.push_back(row(ACC_READ,  32'h0000_D000));
    rows.push_back(row(ACC_WRITE, 32'h0000_703F));
    rows.push_back(row(ACC_READ,  32'h0000_803F));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct   = 28;
    receiver_idle_pct = 76;
    foreach (rows[i]) begin
      known_answers.push_back({rows[i].given, rows[i].res});
      send_access(rows[i].act, rows[i].addr);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 28 : (phase == 1) ? 76 : 0;
      receiver_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 28 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_access(access_t'($urandom_range(1)), rand_addr());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/scd_store.sv
rtl/scd_policy.sv
rtl/set_assoc_writeback_cache_directory.sv
test/tb_set_assoc_writeback_cache_directory.sv
